[rtl/lpcp_pkg.sv]
`timescale 1ns / 1ps
package lpcp_pkg;

	localparam int COORD_WIDTH = 32;
	localparam int DIFF_WIDTH = COORD_WIDTH + 1;
	localparam int QUEUE_DEPTH = 2;

	localparam logic [1:0] ST_OK = 2'd0;
	localparam logic [1:0] ST_PARALLEL = 2'd1;

	typedef enum logic [1:0] {
		KIND_NORM,
		KIND_SHARED,
		KIND_PAR
	} kind_t;

	typedef struct packed {
		logic signed [COORD_WIDTH-1:0] a_start_x;
		logic signed [COORD_WIDTH-1:0] a_start_y;
		logic signed [COORD_WIDTH-1:0] a_start_z;
		logic signed [COORD_WIDTH-1:0] a_end_x;
		logic signed [COORD_WIDTH-1:0] a_end_y;
		logic signed [COORD_WIDTH-1:0] a_end_z;
		logic signed [COORD_WIDTH-1:0] b_start_x;
		logic signed [COORD_WIDTH-1:0] b_start_y;
		logic signed [COORD_WIDTH-1:0] b_start_z;
		logic signed [COORD_WIDTH-1:0] b_end_x;
		logic signed [COORD_WIDTH-1:0] b_end_y;
		logic signed [COORD_WIDTH-1:0] b_end_z;
	} in_word_t;

	typedef struct packed {
		logic signed [COORD_WIDTH-1:0] foot_a_x;
		logic signed [COORD_WIDTH-1:0] foot_a_y;
		logic signed [COORD_WIDTH-1:0] foot_a_z;
		logic signed [COORD_WIDTH-1:0] foot_b_x;
		logic signed [COORD_WIDTH-1:0] foot_b_y;
		logic signed [COORD_WIDTH-1:0] foot_b_z;
		logic [1:0] status;
	} out_word_t;

	typedef struct packed {
		kind_t kind;
		logic [2:0][COORD_WIDTH-1:0] sp;
		logic [2:0][COORD_WIDTH-1:0] mp;
		logic [2:0][DIFF_WIDTH-1:0] d1;
		logic [2:0][DIFF_WIDTH-1:0] d2;
		logic [2:0][DIFF_WIDTH-1:0] wv;
	} front_word_t;

endpackage

[rtl/lpcp_front.sv]
`timescale 1ns / 1ps
module lpcp_front (
	input lpcp_pkg::in_word_t in_word,
	output lpcp_pkg::front_word_t fw
);

	localparam int W = lpcp_pkg::COORD_WIDTH;
	localparam int D = lpcp_pkg::DIFF_WIDTH;

	logic [2:0][W-1:0] as_p, ae_p, bs_p, be_p, hit_p;
	logic hit;

	assign as_p = {in_word.a_start_z, in_word.a_start_y, in_word.a_start_x};
	assign ae_p = {in_word.a_end_z, in_word.a_end_y, in_word.a_end_x};
	assign bs_p = {in_word.b_start_z, in_word.b_start_y, in_word.b_start_x};
	assign be_p = {in_word.b_end_z, in_word.b_end_y, in_word.b_end_x};

	always_comb begin
		hit = 1'b1;
		hit_p = as_p;
		if (as_p == bs_p || as_p == be_p) begin
			hit_p = as_p;
		end else if (ae_p == bs_p || ae_p == be_p) begin
			hit_p = ae_p;
		end else begin
			hit = 1'b0;
		end
	end

	always_comb begin
		fw.kind = hit ? lpcp_pkg::KIND_SHARED : lpcp_pkg::KIND_NORM;
		fw.sp = hit ? hit_p : as_p;
		fw.mp = hit ? hit_p : bs_p;
		for (int k = 0; k < 3; k++) begin
			fw.d1[k] = D'($signed(ae_p[k])) - D'($signed(as_p[k]));
			fw.d2[k] = D'($signed(be_p[k])) - D'($signed(bs_p[k]));
			fw.wv[k] = D'($signed(bs_p[k])) - D'($signed(as_p[k]));
		end
	end

endmodule

[rtl/lpcp_queue.sv]
`timescale 1ns / 1ps
module lpcp_queue #(
	parameter int DEPTH = lpcp_pkg::QUEUE_DEPTH
) (
	input logic clk,
	input logic arst_n,
	input logic push,
	input lpcp_pkg::front_word_t wdata,
	output logic full,
	input logic pop,
	output lpcp_pkg::front_word_t rdata,
	output logic avail
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	lpcp_pkg::front_word_t mem_q [DEPTH];
	logic [PW-1:0] wr_q, rd_q;
	logic [PW:0] cnt_q;

	assign full = (cnt_q == (PW+1)'(DEPTH));
	assign avail = (cnt_q != '0);
	assign rdata = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == PW'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= (rd_q == PW'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

[rtl/lpcp_back.sv]
`timescale 1ns / 1ps
module lpcp_back (
	input logic clk,
	input logic arst_n,
	input lpcp_pkg::front_word_t entry,
	input logic avail,
	output logic pop,
	output logic out_valid,
	input logic out_stall,
	output lpcp_pkg::out_word_t out_data
);

	localparam int W = lpcp_pkg::COORD_WIDTH;
	localparam int D = lpcp_pkg::DIFF_WIDTH;
	localparam int NW = 2 * D + 1;
	localparam int NNW = 4 * D + 3;
	localparam int TW = 4 * D + 4;
	localparam int PW = TW + D;
	localparam int UW = PW + 2;
	localparam int NPW = UW + 1;
	localparam int RW = NPW + 1;
	localparam int DQ = W + 2;
	localparam int QW = DQ + 2;
	localparam int SW = QW + 1;
	localparam int LW = D + 1;
	localparam int PAW = 2 * LW;
	localparam int PBW = LW + D;
	localparam int NL = 5;
	localparam logic signed [SW-1:0] SAT_HI = SW'((64'sd1 <<< (W - 1)) - 64'sd1);
	localparam logic signed [SW-1:0] SAT_LO = -SAT_HI - SW'(1);

	function automatic logic signed [NW-1:0] xterm(input logic signed [D-1:0] p,
			input logic signed [D-1:0] q, input logic signed [D-1:0] r,
			input logic signed [D-1:0] s);
		return NW'(p) * NW'(q) - NW'(r) * NW'(s);
	endfunction

	function automatic logic signed [LW-1:0] lo_limb(input logic signed [NW-1:0] v);
		return $signed({1'b0, v[D-1:0]});
	endfunction

	function automatic logic signed [LW-1:0] hi_limb(input logic signed [NW-1:0] v);
		return $signed(v[NW-1:D]);
	endfunction

	logic en;
	logic out_valid_q;
	lpcp_pkg::out_word_t out_q;

	assign en = !(out_valid_q && out_stall);
	assign pop = en && avail;
	assign out_valid = out_valid_q;
	assign out_data = out_q;

	logic v_s1;
	lpcp_pkg::front_word_t e_s1;

	logic signed [D-1:0] a1 [3], a2 [3], aw [3];
	logic signed [NW-1:0] n_c [3], t2_c [3], t1_c [3];

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			a1[k] = $signed(e_s1.d1[k]);
			a2[k] = $signed(e_s1.d2[k]);
			aw[k] = $signed(e_s1.wv[k]);
		end
		n_c[0] = xterm(a1[1], a2[2], a1[2], a2[1]);
		n_c[1] = xterm(a1[2], a2[0], a1[0], a2[2]);
		n_c[2] = xterm(a1[0], a2[1], a1[1], a2[0]);
		t2_c[0] = xterm(aw[1], a2[2], aw[2], a2[1]);
		t2_c[1] = xterm(aw[2], a2[0], aw[0], a2[2]);
		t2_c[2] = xterm(aw[0], a2[1], aw[1], a2[0]);
		t1_c[0] = xterm(aw[1], a1[2], aw[2], a1[1]);
		t1_c[1] = xterm(aw[2], a1[0], aw[0], a1[2]);
		t1_c[2] = xterm(aw[0], a1[1], aw[1], a1[0]);
	end

	logic v_s2;
	lpcp_pkg::kind_t kind_s2;
	logic [2:0][W-1:0] sp_s2, mp_s2;
	logic signed [D-1:0] d1_s2 [3], d2_s2 [3];
	logic signed [NW-1:0] n_s2 [3], t2_s2 [3], t1_s2 [3];

	logic signed [NW-1:0] xa [9], ya [9];
	logic signed [PAW-1:0] pa_c [9][4];

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			xa[k] = n_s2[k];
			ya[k] = n_s2[k];
			xa[k+3] = n_s2[k];
			ya[k+3] = t2_s2[k];
			xa[k+6] = n_s2[k];
			ya[k+6] = t1_s2[k];
		end
		for (int p = 0; p < 9; p++) begin
			pa_c[p][0] = PAW'(lo_limb(xa[p])) * PAW'(lo_limb(ya[p]));
			pa_c[p][1] = PAW'(lo_limb(xa[p])) * PAW'(hi_limb(ya[p]));
			pa_c[p][2] = PAW'(hi_limb(xa[p])) * PAW'(lo_limb(ya[p]));
			pa_c[p][3] = PAW'(hi_limb(xa[p])) * PAW'(hi_limb(ya[p]));
		end
	end

	logic v_s3;
	lpcp_pkg::kind_t kind_s3;
	logic [2:0][W-1:0] sp_s3, mp_s3;
	logic signed [D-1:0] d1_s3 [3], d2_s3 [3];
	logic signed [PAW-1:0] pa_s3 [9][4];

	logic signed [TW-1:0] pf [9];
	logic signed [TW-1:0] nn_c, ta_c, tb_c;

	always_comb begin
		for (int p = 0; p < 9; p++) begin
			pf[p] = TW'(pa_s3[p][0]) + (TW'(pa_s3[p][1]) <<< D) + (TW'(pa_s3[p][2]) <<< D)
				+ (TW'(pa_s3[p][3]) <<< (2 * D));
		end
		nn_c = '0;
		ta_c = '0;
		tb_c = '0;
		for (int k = 0; k < 3; k++) begin
			nn_c = nn_c + pf[k];
			ta_c = ta_c + pf[k+3];
			tb_c = tb_c + pf[k+6];
		end
	end

	logic v_s4;
	lpcp_pkg::kind_t kind_s4;
	logic [2:0][W-1:0] sp_s4, mp_s4;
	logic signed [D-1:0] d1_s4 [3], d2_s4 [3];
	logic [NNW-1:0] nn_s4;
	logic signed [TW-1:0] ta_s4, tb_s4;

	logic signed [LW-1:0] tal [NL], tbl [NL];
	logic signed [PBW-1:0] pb_c [6][NL];

	always_comb begin
		for (int l = 0; l < NL - 1; l++) begin
			tal[l] = $signed({1'b0, ta_s4[l*D +: D]});
			tbl[l] = $signed({1'b0, tb_s4[l*D +: D]});
		end
		tal[NL-1] = LW'($signed(ta_s4[TW-1:4*D]));
		tbl[NL-1] = LW'($signed(tb_s4[TW-1:4*D]));
		for (int k = 0; k < 3; k++) begin
			for (int l = 0; l < NL; l++) begin
				pb_c[k][l] = PBW'(tal[l]) * PBW'(d1_s4[k]);
				pb_c[k+3][l] = PBW'(tbl[l]) * PBW'(d2_s4[k]);
			end
		end
	end

	logic v_s5;
	lpcp_pkg::kind_t kind_s5;
	logic [2:0][W-1:0] sp_s5, mp_s5;
	logic [NNW-1:0] nn_s5;
	logic signed [PBW-1:0] pb_s5 [6][NL];

	logic signed [PW-1:0] prod_c [6];

	always_comb begin
		for (int i = 0; i < 6; i++) begin
			prod_c[i] = '0;
			for (int l = 0; l < NL; l++) begin
				prod_c[i] = prod_c[i] + (PW'(pb_s5[i][l]) <<< (l * D));
			end
		end
	end

	logic v_s6;
	lpcp_pkg::kind_t kind_s6;
	logic [2:0][W-1:0] sp_s6, mp_s6;
	logic [NNW-1:0] nn_s6;
	logic signed [PW-1:0] prod_s6 [6];

	logic [NNW:0] den2_c;
	logic signed [UW-1:0] num_c [6];
	logic signed [NPW-1:0] numx_c [6];
	logic [NPW-1:0] mag_c [6], npos_c [6];
	logic [5:0] neg_c, cap_c;

	always_comb begin
		den2_c = {nn_s6, 1'b0};
		for (int i = 0; i < 6; i++) begin
			num_c[i] = (UW'(prod_s6[i]) <<< 1) + $signed(UW'(nn_s6));
			numx_c[i] = NPW'(num_c[i]);
			neg_c[i] = num_c[i][UW-1];
			mag_c[i] = neg_c[i] ? NPW'(-numx_c[i]) : NPW'(numx_c[i]);
			npos_c[i] = neg_c[i] ? mag_c[i] + NPW'(den2_c) - NPW'(1) : mag_c[i];
			cap_c[i] = RW'(npos_c[i]) >= (RW'(den2_c) << DQ);
		end
	end

	logic v_s7 [DQ+1];
	lpcp_pkg::kind_t kind_s7 [DQ+1];
	logic [2:0][W-1:0] sp_s7 [DQ+1];
	logic [2:0][W-1:0] mp_s7 [DQ+1];
	logic [NNW:0] den_s7 [DQ+1];
	logic [5:0] neg_s7 [DQ+1];
	logic [5:0] cap_s7 [DQ+1];
	logic [NPW-1:0] r_s7 [DQ+1][6];
	logic [DQ-1:0] q_s7 [DQ+1][6];

	logic [NPW-1:0] rn [DQ][6];
	logic [DQ-1:0] qn [DQ][6];
	logic [RW-1:0] shv [DQ];

	always_comb begin
		for (int j = 0; j < DQ; j++) begin
			shv[j] = RW'(den_s7[j]) << (DQ - 1 - j);
			for (int i = 0; i < 6; i++) begin
				if (RW'(r_s7[j][i]) >= shv[j]) begin
					rn[j][i] = r_s7[j][i] - NPW'(shv[j]);
					qn[j][i] = q_s7[j][i] | (DQ'(1) << (DQ - 1 - j));
				end else begin
					rn[j][i] = r_s7[j][i];
					qn[j][i] = q_s7[j][i];
				end
			end
		end
	end

	logic [QW-1:0] qq [6];
	logic signed [QW-1:0] qs [6];
	logic signed [SW-1:0] sum [6];
	logic [W-1:0] foot [6];
	logic [W-1:0] base [6];

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			base[k] = sp_s7[DQ][k];
			base[k+3] = mp_s7[DQ][k];
		end
		for (int i = 0; i < 6; i++) begin
			qq[i] = cap_s7[DQ][i] ? (QW'(1) << DQ) : QW'(q_s7[DQ][i]);
			qs[i] = neg_s7[DQ][i] ? -$signed(qq[i]) : $signed(qq[i]);
			sum[i] = SW'($signed(base[i])) + SW'(qs[i]);
			if (sum[i] > SAT_HI) begin
				foot[i] = SAT_HI[W-1:0];
			end else if (sum[i] < SAT_LO) begin
				foot[i] = SAT_LO[W-1:0];
			end else begin
				foot[i] = sum[i][W-1:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			e_s1 <= entry;

			kind_s2 <= (e_s1.kind == lpcp_pkg::KIND_NORM && n_c[1] == '0) ?
				lpcp_pkg::KIND_PAR : e_s1.kind;
			sp_s2 <= e_s1.sp;
			mp_s2 <= e_s1.mp;
			for (int k = 0; k < 3; k++) begin
				d1_s2[k] <= a1[k];
				d2_s2[k] <= a2[k];
				n_s2[k] <= n_c[k];
				t2_s2[k] <= t2_c[k];
				t1_s2[k] <= t1_c[k];
			end

			kind_s3 <= kind_s2;
			sp_s3 <= sp_s2;
			mp_s3 <= mp_s2;
			d1_s3 <= d1_s2;
			d2_s3 <= d2_s2;
			pa_s3 <= pa_c;

			kind_s4 <= kind_s3;
			sp_s4 <= sp_s3;
			mp_s4 <= mp_s3;
			d1_s4 <= d1_s3;
			d2_s4 <= d2_s3;
			nn_s4 <= NNW'(nn_c);
			ta_s4 <= ta_c;
			tb_s4 <= tb_c;

			kind_s5 <= kind_s4;
			sp_s5 <= sp_s4;
			mp_s5 <= mp_s4;
			nn_s5 <= nn_s4;
			pb_s5 <= pb_c;

			kind_s6 <= kind_s5;
			sp_s6 <= sp_s5;
			mp_s6 <= mp_s5;
			nn_s6 <= nn_s5;
			prod_s6 <= prod_c;

			kind_s7[0] <= kind_s6;
			sp_s7[0] <= sp_s6;
			mp_s7[0] <= mp_s6;
			den_s7[0] <= den2_c;
			neg_s7[0] <= neg_c;
			cap_s7[0] <= cap_c;
			for (int i = 0; i < 6; i++) begin
				r_s7[0][i] <= npos_c[i];
				q_s7[0][i] <= '0;
			end
			for (int j = 0; j < DQ; j++) begin
				kind_s7[j+1] <= kind_s7[j];
				sp_s7[j+1] <= sp_s7[j];
				mp_s7[j+1] <= mp_s7[j];
				den_s7[j+1] <= den_s7[j];
				neg_s7[j+1] <= neg_s7[j];
				cap_s7[j+1] <= cap_s7[j];
				for (int i = 0; i < 6; i++) begin
					r_s7[j+1][i] <= rn[j][i];
					q_s7[j+1][i] <= qn[j][i];
				end
			end

			case (kind_s7[DQ])
				lpcp_pkg::KIND_SHARED: begin
					out_q.foot_a_x <= sp_s7[DQ][0];
					out_q.foot_a_y <= sp_s7[DQ][1];
					out_q.foot_a_z <= sp_s7[DQ][2];
					out_q.foot_b_x <= mp_s7[DQ][0];
					out_q.foot_b_y <= mp_s7[DQ][1];
					out_q.foot_b_z <= mp_s7[DQ][2];
					out_q.status <= lpcp_pkg::ST_OK;
				end
				lpcp_pkg::KIND_NORM: begin
					out_q.foot_a_x <= foot[0];
					out_q.foot_a_y <= foot[1];
					out_q.foot_a_z <= foot[2];
					out_q.foot_b_x <= foot[3];
					out_q.foot_b_y <= foot[4];
					out_q.foot_b_z <= foot[5];
					out_q.status <= lpcp_pkg::ST_OK;
				end
				default: begin
					out_q.foot_a_x <= '0;
					out_q.foot_a_y <= '0;
					out_q.foot_a_z <= '0;
					out_q.foot_b_x <= '0;
					out_q.foot_b_y <= '0;
					out_q.foot_b_z <= '0;
					out_q.status <= lpcp_pkg::ST_PARALLEL;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			for (int j = 0; j <= DQ; j++) begin
				v_s7[j] <= 1'b0;
			end
			out_valid_q <= 1'b0;
		end else if (en) begin
			v_s1 <= avail;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
			v_s7[0] <= v_s6;
			for (int j = 0; j < DQ; j++) begin
				v_s7[j+1] <= v_s7[j];
			end
			out_valid_q <= v_s7[DQ];
		end
	end

endmodule

[rtl/line_pair_closest_points.sv]
`timescale 1ns / 1ps
// Channel   Direction   Handshake                Word
// in        input       in_valid / in_stall      lpcp_pkg::in_word_t
// out       output      out_valid / out_stall    lpcp_pkg::out_word_t
//
// One word is accepted per cycle while in_stall is low. The quotient pipeline retires one
// quotient bit per stage.
// The wide products are split into limb products and take two stages each.
// Reset clears the queue and every pipeline valid bit.
// A stall on out while out_valid is high freezes the back pipeline; the queue of QUEUE_DEPTH
// words keeps taking input until it fills, and in_stall reflects only that it is full.
module line_pair_closest_points #(
	parameter int QUEUE_DEPTH = lpcp_pkg::QUEUE_DEPTH
) (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_stall,
	input lpcp_pkg::in_word_t in_data,
	output logic out_valid,
	input logic out_stall,
	output lpcp_pkg::out_word_t out_data
);

	lpcp_pkg::front_word_t fw, qw;
	logic full, avail, pop;

	assign in_stall = full;

	lpcp_front u_front (
		.in_word(in_data),
		.fw(fw)
	);

	lpcp_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push(in_valid && !full),
		.wdata(fw),
		.full(full),
		.pop(pop),
		.rdata(qw),
		.avail(avail)
	);

	lpcp_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.entry(qw),
		.avail(avail),
		.pop(pop),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_data(out_data)
	);

endmodule
